/* src/skl_pkg.sv */
// Package for the keyed lookup table: sizes, payload structs, operation codes.
// Used by skl_match and the top level; depends on nothing.
`default_nettype none
package skl_pkg;

  localparam int Entries = 8;
  localparam int IdxW    = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int KeyW    = 32;
  localparam int CodeW   = 8;
  localparam int OpW     = 2;
  localparam int CfgIdxW = 1;
  localparam int EntryW  = KeyW + CodeW;

  typedef enum logic [OpW-1:0] {
    OpSet   = 2'd0,
    OpGet   = 2'd1,
    OpClear = 2'd2,
    OpNop   = 2'd3
  } op_e;

  localparam logic [CfgIdxW-1:0] CfgUnknownCode = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgSpecialCode = 1'b1;

  typedef struct packed {
    logic [OpW-1:0]   operation;
    logic [KeyW-1:0]  lookup_key;
    logic [CodeW-1:0] write_code;
  } in_item_t;

  typedef struct packed {
    logic [CodeW-1:0] read_code;
    logic             was_present;
    logic             is_special_code;
  } out_item_t;

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [CodeW-1:0] code;
  } entry_t;

  typedef struct packed {
    logic             hit;
    logic [IdxW-1:0]  hit_idx;
    logic [CodeW-1:0] hit_code;
    logic             free;
    logic [IdxW-1:0]  free_idx;
  } match_t;

endpackage
`default_nettype wire

/* src/skl_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependency.
`default_nettype none
module skl_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                            wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                            rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* src/skl_match.sv */
// Match tracker: compares each entry read back from the table RAM against the key
// and keeps the first hit and the first empty slot. Depends on skl_pkg.
`default_nettype none
module skl_match (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        clr_i,
  input  wire logic                        chk_i,
  input  wire logic [skl_pkg::IdxW-1:0]    chk_idx_i,
  input  wire logic [skl_pkg::KeyW-1:0]    key_i,
  input  wire skl_pkg::entry_t             entry_i,
  input  wire logic                        entry_vld_i,
  output skl_pkg::match_t                  match_o
);

  skl_pkg::match_t m_d, m_q;

  always_comb begin
    m_d = m_q;
    if (clr_i) begin
      m_d.hit      = 1'b0;
      m_d.hit_idx  = '0;
      m_d.hit_code = '0;
      m_d.free     = 1'b0;
      m_d.free_idx = '0;
    end else if (chk_i) begin
      if (!m_q.hit && entry_vld_i && (key_i != '0) && (entry_i.key == key_i)) begin
        m_d.hit      = 1'b1;
        m_d.hit_idx  = chk_idx_i;
        m_d.hit_code = entry_i.code;
      end
      if (!m_q.free && !entry_vld_i) begin
        m_d.free     = 1'b1;
        m_d.free_idx = chk_idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q <= '0;
    end else begin
      m_q <= m_d;
    end
  end

  assign match_o = m_q;

endmodule
`default_nettype wire

/* src/small_keyed_lookup_table.sv */
// Top level of the keyed lookup table: sequencer, configuration registers,
// slot valid bits, table RAM and match tracker. Depends on skl_pkg, skl_ram, skl_match.
//
// Each transaction (set, get or clear) scans every slot of the table RAM, one read
// per cycle, then writes back at most one slot. An accepted item passes through
// StScan, StLast and StWrite; its result is registered at the end of StWrite and
// strobed on done_o for one cycle. busy_o stays high through those states and is
// low only in StIdle, where a start is taken, so a new item is not taken before
// the last one is through. The scan reads the slots through the single RAM read
// port. Results cannot be held off. Empty slots are tracked by per-slot valid bits
// cleared at reset, so the block is ready right after reset with no clearing pass.
`default_nettype none
module small_keyed_lookup_table (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  output logic                                busy_o,
  input  wire skl_pkg::in_item_t              in_item_i,
  output logic                                done_o,
  output skl_pkg::out_item_t                  res_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [skl_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [skl_pkg::CodeW-1:0]      cfg_wdata_i
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StScan  = 2'd1;
  localparam logic [1:0] StLast  = 2'd2;
  localparam logic [1:0] StWrite = 2'd3;

  logic [1:0]                    state_d, state_q;
  logic [skl_pkg::IdxW-1:0]      cnt_d, cnt_q;
  logic                          chk_q;
  logic [skl_pkg::IdxW-1:0]      chk_idx_q;
  skl_pkg::in_item_t             item_q;
  logic [skl_pkg::CodeW-1:0]     unknown_q, special_q;
  logic [skl_pkg::Entries-1:0]   vld_d, vld_q;
  logic                          done_q;
  skl_pkg::out_item_t            res_d, res_q;

  logic                          accept;
  logic                          we;
  logic [skl_pkg::IdxW-1:0]      waddr;
  skl_pkg::entry_t               wdata;
  skl_pkg::entry_t               rdata;
  skl_pkg::match_t               m;

  assign accept = start_i && (state_q == StIdle);
  assign busy_o = (state_q != StIdle);

  skl_ram #(
    .Width (skl_pkg::EntryW),
    .Depth (skl_pkg::Entries)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (cnt_q),
    .rdata_o (rdata)
  );

  skl_match u_match (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clr_i       (accept),
    .chk_i       (chk_q),
    .chk_idx_i   (chk_idx_q),
    .key_i       (item_q.lookup_key),
    .entry_i     (rdata),
    .entry_vld_i (vld_q[chk_idx_q]),
    .match_o     (m)
  );

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      StIdle: begin
        cnt_d = '0;
        if (start_i) begin
          state_d = StScan;
        end
      end
      StScan: begin
        if (cnt_q == skl_pkg::IdxW'(skl_pkg::Entries - 1)) begin
          state_d = StLast;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StLast:  state_d = StWrite;
      StWrite: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // write back the chosen slot
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    vld_d = vld_q;
    if (state_q == StWrite) begin
      if ((item_q.operation == skl_pkg::OpSet) && (item_q.lookup_key != '0)) begin
        we         = 1'b1;
        waddr      = m.hit ? m.hit_idx : (m.free ? m.free_idx : '0);
        wdata.key  = item_q.lookup_key;
        wdata.code = item_q.write_code;
        vld_d[waddr] = 1'b1;
      end else if ((item_q.operation == skl_pkg::OpClear) && m.hit) begin
        we         = 1'b1;
        waddr      = m.hit_idx;
        wdata.key  = '0;
        wdata.code = unknown_q;
        vld_d[waddr] = 1'b0;
      end
    end
  end

  always_comb begin
    res_d.read_code = ((item_q.operation == skl_pkg::OpGet) && m.hit) ? m.hit_code
                                                                      : unknown_q;
    res_d.was_present     = m.hit;
    res_d.is_special_code = (res_d.read_code == special_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '0;
      chk_q     <= 1'b0;
      chk_idx_q <= '0;
      vld_q     <= '0;
      done_q    <= 1'b0;
      unknown_q <= '0;
      special_q <= skl_pkg::CodeW'(1);
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      chk_q     <= (state_q == StScan);
      chk_idx_q <= cnt_q;
      vld_q     <= vld_d;
      done_q    <= (state_q == StWrite);
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          skl_pkg::CfgUnknownCode: unknown_q <= cfg_wdata_i;
          skl_pkg::CfgSpecialCode: special_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
    if (state_q == StWrite) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_done_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWrite) |=> done_q)
    else $error("result strobe missing after write-back");

  a_done_only_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(state_q) == StWrite))
    else $error("result strobe without write-back");

  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == StScan) && (cnt_q == '0))
    else $error("transaction did not start a scan from slot zero");

  a_hit_is_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StWrite) && m.hit) |-> (vld_q[m.hit_idx] && (item_q.lookup_key != '0)))
    else $error("hit on an empty slot or with a zero key");

endmodule
`default_nettype wire
